// ===== design/tstxt_pkg.sv =====
// ----------------------------------------------------------------------------
// tstxt_pkg
// Shared types, constants and helpers for the timestamp text to seconds block.
// ----------------------------------------------------------------------------
package tstxt_pkg;

    localparam logic [30:0] MAX_SECONDS = 31'h7FFF_FFFF;
    localparam logic [30:0] GROUP_LIMIT = 31'd60;
    localparam logic [11:0] UNIT_W_H    = 12'd3600;
    localparam logic [11:0] UNIT_W_M    = 12'd60;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_COLON,
        CLS_UNIT_H,
        CLS_UNIT_M,
        CLS_UNIT_S,
        CLS_ALPHA,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } q_entry_t;

    // grammar state as it stands after the last character of a string
    typedef struct packed {
        logic        seen_content;
        logic        text_bad;
        logic        any_letter;
        logic        units_bad;
        logic [30:0] unit_number;
        logic [30:0] unit_total;
        logic        colon_bad;
        logic        colon_have_digit;
        logic [30:0] colon_part;
        logic [30:0] colon_total;
        logic [1:0]  colon_count;
    } fin_snap_t;

    // total * 60 + part
    function automatic logic [37:0] colon_fold(input logic [30:0] total,
                                               input logic [30:0] part);
        logic [37:0] t;
        t = {7'b0, total};
        return (t << 6) - (t << 2) + {7'b0, part};
    endfunction

endpackage

// ===== design/tstxt_front.sv =====
// ----------------------------------------------------------------------------
// tstxt_front
// Classifies each incoming character and queues it for the grammar engine.
// ----------------------------------------------------------------------------
module tstxt_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] character
    input  logic               s_tlast,   // last
    output logic               q_valid,
    output tstxt_pkg::q_entry_t q_entry,
    input  logic               q_ready
);
    import tstxt_pkg::*;

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_UC_A  = 8'h41;
    localparam logic [7:0] CHR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHR_LC_A  = 8'h61;
    localparam logic [7:0] CHR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHR_LC_H  = 8'h68;
    localparam logic [7:0] CHR_LC_M  = 8'h6D;
    localparam logic [7:0] CHR_LC_S  = 8'h73;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    q_entry_t    q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    q_entry_t    in_entry;
    logic [7:0]  lower;
    logic        push;
    logic        pop;

    // classify: fold upper case onto lower case for the unit letters
    always_comb
    begin
        lower          = s_tdata | CASE_BIT;
        in_entry.digit = s_tdata[3:0] - CHR_ZERO[3:0];
        in_entry.last  = s_tlast;
        if (s_tdata == CHR_SPACE || (s_tdata >= CHR_TAB && s_tdata <= CHR_CR))
            in_entry.cls = CLS_SPACE;
        else if (s_tdata >= CHR_ZERO && s_tdata <= CHR_NINE)
            in_entry.cls = CLS_DIGIT;
        else if (s_tdata == CHR_COLON)
            in_entry.cls = CLS_COLON;
        else if ((s_tdata >= CHR_UC_A && s_tdata <= CHR_UC_Z)
                 || (s_tdata >= CHR_LC_A && s_tdata <= CHR_LC_Z))
        begin
            if (lower == CHR_LC_H)
                in_entry.cls = CLS_UNIT_H;
            else if (lower == CHR_LC_M)
                in_entry.cls = CLS_UNIT_M;
            else if (lower == CHR_LC_S)
                in_entry.cls = CLS_UNIT_S;
            else
                in_entry.cls = CLS_ALPHA;
        end
        else
            in_entry.cls = CLS_OTHER;
    end

    assign s_tready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= in_entry;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/tstxt_back.sv =====
// ----------------------------------------------------------------------------
// tstxt_back
// Runs the unit grammar and the colon grammar side by side, one word a cycle; a last word waits for fin_ready.
// ----------------------------------------------------------------------------
module tstxt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  tstxt_pkg::q_entry_t  q_entry,
    output logic                 q_ready,
    input  logic                 fin_ready,
    output logic                 fin_load,
    output tstxt_pkg::fin_snap_t fin_snap
);
    import tstxt_pkg::*;

    logic        seen_content_reg, seen_content_next;
    logic        space_after_reg, space_after_next;
    logic        text_bad_reg, text_bad_next;
    logic        any_letter_reg, any_letter_next;
    logic        units_bad_reg, units_bad_next;
    logic [30:0] unit_number_reg, unit_number_next;
    logic [36:0] unit_n60_reg, unit_n60_next;
    logic [42:0] unit_n3600_reg, unit_n3600_next;
    logic [30:0] unit_total_reg, unit_total_next;
    logic        unit_have_reg, unit_have_next;
    logic        colon_bad_reg, colon_bad_next;
    logic [30:0] colon_part_reg, colon_part_next;
    logic [30:0] colon_total_reg, colon_total_next;
    logic        colon_have_reg, colon_have_next;
    logic [1:0]  colon_count_reg, colon_count_next;

    logic        pop;
    logic [34:0] num_x10;
    logic [40:0] n60_x10;
    logic [46:0] n3600_x10;
    logic [34:0] part_x10;
    logic [42:0] unit_prod;
    logic [43:0] unit_sum;
    logic [37:0] fold;

    assign q_ready  = !q_entry.last || fin_ready;
    assign pop      = q_valid && q_ready;
    assign fin_load = pop && q_entry.last;

    // the scaled copies of the run let a unit letter cost one add
    always_comb
    begin
        num_x10   = ({4'b0, unit_number_reg} << 3) + ({4'b0, unit_number_reg} << 1)
                    + {31'b0, q_entry.digit};
        n60_x10   = ({4'b0, unit_n60_reg} << 3) + ({4'b0, unit_n60_reg} << 1)
                    + 41'(q_entry.digit) * 41'(UNIT_W_M);
        n3600_x10 = ({4'b0, unit_n3600_reg} << 3) + ({4'b0, unit_n3600_reg} << 1)
                    + 47'(q_entry.digit) * 47'(UNIT_W_H);
        part_x10  = ({4'b0, colon_part_reg} << 3) + ({4'b0, colon_part_reg} << 1)
                    + {31'b0, q_entry.digit};
        case (q_entry.cls)
            CLS_UNIT_H: unit_prod = unit_n3600_reg;
            CLS_UNIT_M: unit_prod = {6'b0, unit_n60_reg};
            default:    unit_prod = {12'b0, unit_number_reg};
        endcase
        unit_sum = {13'b0, unit_total_reg} + {1'b0, unit_prod};
        fold     = colon_fold(colon_total_reg, colon_part_reg);
    end

    always_comb
    begin
        seen_content_next = seen_content_reg;
        space_after_next  = space_after_reg;
        text_bad_next     = text_bad_reg;
        any_letter_next   = any_letter_reg;
        units_bad_next    = units_bad_reg;
        unit_number_next  = unit_number_reg;
        unit_n60_next     = unit_n60_reg;
        unit_n3600_next   = unit_n3600_reg;
        unit_total_next   = unit_total_reg;
        unit_have_next    = unit_have_reg;
        colon_bad_next    = colon_bad_reg;
        colon_part_next   = colon_part_reg;
        colon_total_next  = colon_total_reg;
        colon_have_next   = colon_have_reg;
        colon_count_next  = colon_count_reg;

        if (pop)
        begin
            if (q_entry.cls == CLS_SPACE)
            begin
                if (seen_content_reg)
                    space_after_next = 1'b1;
            end
            else
            begin
                if (space_after_reg)
                    text_bad_next = 1'b1;
                seen_content_next = 1'b1;
                if (q_entry.cls == CLS_UNIT_H || q_entry.cls == CLS_UNIT_M
                    || q_entry.cls == CLS_UNIT_S || q_entry.cls == CLS_ALPHA)
                    any_letter_next = 1'b1;

                if (!units_bad_reg)
                begin
                    case (q_entry.cls) inside
                        CLS_DIGIT:
                        begin
                            unit_number_next = num_x10[30:0];
                            unit_n60_next    = n60_x10[36:0];
                            unit_n3600_next  = n3600_x10[42:0];
                            unit_have_next   = 1'b1;
                            if (num_x10 > 35'(MAX_SECONDS))
                                units_bad_next = 1'b1;
                        end
                        CLS_UNIT_H, CLS_UNIT_M, CLS_UNIT_S:
                        begin
                            if (!unit_have_reg)
                                units_bad_next = 1'b1;
                            else
                            begin
                                unit_total_next  = unit_sum[30:0];
                                unit_number_next = '0;
                                unit_n60_next    = '0;
                                unit_n3600_next  = '0;
                                unit_have_next   = 1'b0;
                                if (unit_sum > 44'(MAX_SECONDS))
                                    units_bad_next = 1'b1;
                            end
                        end
                        default: units_bad_next = 1'b1;
                    endcase
                end

                if (!colon_bad_reg)
                begin
                    case (q_entry.cls)
                        CLS_COLON:
                        begin
                            if (!colon_have_reg)
                                colon_bad_next = 1'b1;
                            else
                            begin
                                if ((colon_count_reg != 2'd0 && colon_part_reg >= GROUP_LIMIT)
                                    || fold > 38'(MAX_SECONDS))
                                    colon_bad_next = 1'b1;
                                colon_total_next = fold[30:0];
                                if (colon_count_reg != 2'd3)
                                    colon_count_next = colon_count_reg + 2'd1;
                                if (colon_count_reg >= 2'd2)
                                    colon_bad_next = 1'b1;
                                colon_part_next = '0;
                                colon_have_next = 1'b0;
                            end
                        end
                        CLS_DIGIT:
                        begin
                            colon_part_next = part_x10[30:0];
                            colon_have_next = 1'b1;
                            if (part_x10 > 35'(MAX_SECONDS))
                                colon_bad_next = 1'b1;
                        end
                        default: colon_bad_next = 1'b1;
                    endcase
                end
            end
        end

        fin_snap.seen_content     = seen_content_next;
        fin_snap.text_bad         = text_bad_next;
        fin_snap.any_letter       = any_letter_next;
        fin_snap.units_bad        = units_bad_next;
        fin_snap.unit_number      = unit_number_next;
        fin_snap.unit_total       = unit_total_next;
        fin_snap.colon_bad        = colon_bad_next;
        fin_snap.colon_have_digit = colon_have_next;
        fin_snap.colon_part       = colon_part_next;
        fin_snap.colon_total      = colon_total_next;
        fin_snap.colon_count      = colon_count_next;

        // hand the string off and start clean for the next one
        if (fin_load)
        begin
            seen_content_next = 1'b0;
            space_after_next  = 1'b0;
            text_bad_next     = 1'b0;
            any_letter_next   = 1'b0;
            units_bad_next    = 1'b0;
            unit_number_next  = '0;
            unit_n60_next     = '0;
            unit_n3600_next   = '0;
            unit_total_next   = '0;
            unit_have_next    = 1'b0;
            colon_bad_next    = 1'b0;
            colon_part_next   = '0;
            colon_total_next  = '0;
            colon_have_next   = 1'b0;
            colon_count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_content_reg <= 1'b0;
            space_after_reg  <= 1'b0;
            text_bad_reg     <= 1'b0;
            any_letter_reg   <= 1'b0;
            units_bad_reg    <= 1'b0;
            unit_number_reg  <= '0;
            unit_n60_reg     <= '0;
            unit_n3600_reg   <= '0;
            unit_total_reg   <= '0;
            unit_have_reg    <= 1'b0;
            colon_bad_reg    <= 1'b0;
            colon_part_reg   <= '0;
            colon_total_reg  <= '0;
            colon_have_reg   <= 1'b0;
            colon_count_reg  <= '0;
        end
        else
        begin
            seen_content_reg <= seen_content_next;
            space_after_reg  <= space_after_next;
            text_bad_reg     <= text_bad_next;
            any_letter_reg   <= any_letter_next;
            units_bad_reg    <= units_bad_next;
            unit_number_reg  <= unit_number_next;
            unit_n60_reg     <= unit_n60_next;
            unit_n3600_reg   <= unit_n3600_next;
            unit_total_reg   <= unit_total_next;
            unit_have_reg    <= unit_have_next;
            colon_bad_reg    <= colon_bad_next;
            colon_part_reg   <= colon_part_next;
            colon_total_reg  <= colon_total_next;
            colon_have_reg   <= colon_have_next;
            colon_count_reg  <= colon_count_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> !seen_content_reg && !colon_bad_reg && !units_bad_reg
                     && colon_count_reg == 2'd0)
        else $error("grammar state not cleared after last word");

    a_third_colon_bad: assert property (@(posedge clk) disable iff (!rst_n)
        colon_count_reg == 2'd3 |-> colon_bad_reg)
        else $error("third colon without colon grammar failure");

    a_units_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        units_bad_reg && !fin_load |=> units_bad_reg)
        else $error("unit grammar failure cleared inside a string");

endmodule

// ===== design/tstxt_finish.sv =====
// ----------------------------------------------------------------------------
// tstxt_finish
// Closes out both grammars for a finished string and holds the result word.
// ----------------------------------------------------------------------------
module tstxt_finish
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fin_load,
    input  tstxt_pkg::fin_snap_t fin_snap,
    output logic                 fin_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [30:0] seconds, [31] zero
    output logic                 m_tuser    // valid_res
);
    import tstxt_pkg::*;

    logic        fin_valid_reg, fin_valid_next;
    fin_snap_t   snap_reg;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_secs_reg;
    logic        out_ok_reg;

    logic        advance;
    logic [31:0] unit_sum;
    logic [37:0] fold;
    logic        units_bad;
    logic        colon_bad;
    logic        ok;
    logic [30:0] secs;

    assign advance   = fin_valid_reg && (!out_valid_reg || m_tready);
    assign fin_ready = !fin_valid_reg || advance;

    // a bare trailing run counts as seconds; the last colon group folds in
    always_comb
    begin
        unit_sum  = {1'b0, snap_reg.unit_total} + {1'b0, snap_reg.unit_number};
        fold      = colon_fold(snap_reg.colon_total, snap_reg.colon_part);
        units_bad = snap_reg.units_bad || unit_sum > 32'(MAX_SECONDS);
        colon_bad = snap_reg.colon_bad || !snap_reg.colon_have_digit
                    || (snap_reg.colon_count != 2'd0 && snap_reg.colon_part >= GROUP_LIMIT)
                    || fold > 38'(MAX_SECONDS);
        ok        = snap_reg.seen_content && !snap_reg.text_bad
                    && (snap_reg.any_letter ? !units_bad : !colon_bad);
        if (!ok)
            secs = '0;
        else if (snap_reg.any_letter)
            secs = unit_sum[30:0];
        else
            secs = fold[30:0];
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (fin_load)
            fin_valid_next = 1'b1;
        else if (advance)
            fin_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
            snap_reg <= fin_snap;
        if (advance)
        begin
            out_secs_reg <= secs;
            out_ok_reg   <= ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_secs_reg};
    assign m_tuser  = out_ok_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_secs_reg == '0)
        else $error("invalid result carries nonzero seconds");

endmodule

// ===== design/timestamp_text_to_seconds_top.sv =====
// ----------------------------------------------------------------------------
// timestamp_text_to_seconds_top
// Parses a time-offset string, one character a word, into a seconds count.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, with back-to-back strings, while m_tready does not hold results back.
// Path: the word with s_tlast passes the queue, then the grammar step into the finish snapshot
//   register, then the final fold into the result register that drives m_tvalid.
// A four-entry queue sits between the classifier and the grammar engine.
// Reset: rst_n clears the queue, the grammar state and the result valid.
// ----------------------------------------------------------------------------
module timestamp_text_to_seconds_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] seconds, [31] zero
    output logic        m_tuser    // valid_res
);
    import tstxt_pkg::*;

    logic      q_valid;
    q_entry_t  q_entry;
    logic      q_ready;
    logic      fin_ready;
    logic      fin_load;
    fin_snap_t fin_snap;

    tstxt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_ready  (q_ready)
    );

    tstxt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_ready   (q_ready),
        .fin_ready (fin_ready),
        .fin_load  (fin_load),
        .fin_snap  (fin_snap)
    );

    tstxt_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_load  (fin_load),
        .fin_snap  (fin_snap),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
